// ===== rtl/core/oaht_pkg.sv =====
`default_nettype none
package oaht_pkg;

	// fixed field widths
	localparam int KEY_W    = 30;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 7;
	localparam int COUNT_W  = 7;
	localparam int MODE_W   = 2;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [KEY_W-1:0]    key_t;

	// request kinds
	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_SEARCH = 2'd1;
	localparam op_t OP_REMOVE = 2'd2;
	localparam op_t OP_CLEAR  = 2'd3;

	// result codes
	localparam status_t ST_INSERTED  = 3'd0;
	localparam status_t ST_FOUND     = 3'd1;
	localparam status_t ST_REMOVED   = 3'd2;
	localparam status_t ST_NOT_FOUND = 3'd3;
	localparam status_t ST_FULL      = 3'd4;
	localparam status_t ST_CLEARED   = 3'd5;

	// probe step rules
	localparam mode_t MODE_LINEAR = 2'd0;
	localparam mode_t MODE_QUAD   = 2'd1;
	localparam mode_t MODE_DOUBLE = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/core/oaht_if.sv =====
`default_nettype none
// request channel
interface oaht_req_if;
	logic              valid;
	logic              ready;
	oaht_pkg::op_t     opcode;
	oaht_pkg::key_t    key;

	modport source (output valid, output opcode, output key, input ready);
	modport sink (input valid, input opcode, input key, output ready);
endinterface

// response channel
interface oaht_rsp_if;
	logic                          valid;
	logic                          ready;
	oaht_pkg::status_t             status;
	logic [oaht_pkg::SLOT_W-1:0]   slot;
	logic [oaht_pkg::COUNT_W-1:0]  probe_count;

	modport source (output valid, output status, output slot, output probe_count,
		input ready);
	modport sink (input valid, input status, input slot, input probe_count,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/oaht_ram.sv =====
`default_nettype none
module oaht_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 67,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/open_address_hash_table.sv =====
`default_nettype none
// Open-addressed hash table of TABLE_SIZE keys held in one single-port-write RAM;
// a zero entry is empty. Each request beat (insert, search, remove, clear) yields
// one response beat. For insert, search and remove, S_HASH forms the reciprocal
// products for key mod TABLE_SIZE and key mod SECOND_PRIME, S_H2 finishes both
// residues, S_STEP reduces the double-hash step mod TABLE_SIZE, the first S_PROBE
// cycle issues the first RAM read, S_PROBE judges the P slots examined (one RAM
// read per cycle, 1 <= P <= MAX_PROBES), and S_DONE loads the response register.
// Clear, and the pass after reset, sweep the RAM one entry per cycle with no
// request taken meanwhile. The next request is taken in the cycle after the
// response register is loaded; a response still waiting in the output register
// holds the block in its last state. The user must write probe_mode through
// cfg_we/cfg_wdata only between requests, which the block does not enforce; it
// takes effect on the next request; clear the table after changing it.
module open_address_hash_table #(
	parameter int TABLE_SIZE   = 67,
	parameter int SECOND_PRIME = 61,
	parameter int MAX_PROBES   = 67
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [oaht_pkg::MODE_W-1:0]     cfg_wdata,
	oaht_req_if.sink                             req,
	oaht_rsp_if.source                           rsp
);

	localparam int IW  = $clog2(TABLE_SIZE);
	localparam int HW  = $clog2(SECOND_PRIME + 1);
	localparam int CW  = $clog2(MAX_PROBES + 1);
	localparam int KW  = oaht_pkg::KEY_W;
	localparam int PW  = KW + 32;
	localparam int P3W = 2 * HW + 2;

	// floor(x / d) = (x * M) >> S for every x below 2**width, M = ceil(2**S / d)
	localparam int S1 = KW + $clog2(TABLE_SIZE);
	localparam int S2 = KW + $clog2(SECOND_PRIME);
	localparam int S3 = HW + $clog2(TABLE_SIZE);
	localparam logic [31:0] M1 =
		32'(((64'd1 << S1) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));
	localparam logic [31:0] M2 =
		32'(((64'd1 << S2) + 64'(SECOND_PRIME - 1)) / 64'(SECOND_PRIME));
	localparam logic [HW+1:0] M3 =
		(HW+2)'(((64'd1 << S3) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));

	localparam logic [IW:0]   N_EXT   = (IW+1)'(TABLE_SIZE);
	localparam logic [HW-1:0] SP_H    = HW'(SECOND_PRIME);
	localparam logic [HW-1:0] STEP_N  = HW'(TABLE_SIZE);
	localparam logic [KW-1:0] KEY_N   = KW'(TABLE_SIZE);
	localparam logic [KW-1:0] KEY_SP  = KW'(SECOND_PRIME);
	localparam logic [IW-1:0] LAST_IX = IW'(TABLE_SIZE - 1);
	localparam logic [CW-1:0] CAP     = CW'(MAX_PROBES);

	localparam logic [2:0] S_WIPE  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_H2    = 3'd3;
	localparam logic [2:0] S_PROBE = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;
	localparam logic [2:0] S_STEP  = 3'd6;

	logic [2:0]                     state_q;
	oaht_pkg::mode_t                mode_q;
	oaht_pkg::op_t                  op_q;
	oaht_pkg::key_t                 key_q;
	logic [PW-1:0]                  p1_q;
	logic [PW-1:0]                  p2_q;
	logic [IW-1:0]                  r1_q;
	logic [HW-1:0]                  h2_q;
	logic [IW-1:0]                  wipe_cnt_q;
	logic                           wipe_clr_q;
	logic [IW-1:0]                  addr_q;
	logic [IW-1:0]                  inc_q;
	logic [IW-1:0]                  add_q;
	logic [CW-1:0]                  count_q;
	logic                           eval_v_s1;
	logic [IW-1:0]                  eval_idx_s1;
	oaht_pkg::status_t              res_status_q;
	logic [IW-1:0]                  res_slot_q;
	logic [CW-1:0]                  res_count_q;
	logic                           out_valid_q;
	oaht_pkg::status_t              out_status_q;
	logic [oaht_pkg::SLOT_W-1:0]    out_slot_q;
	logic [oaht_pkg::COUNT_W-1:0]   out_count_q;

	logic                           ram_we;
	logic [IW-1:0]                  ram_waddr;
	oaht_pkg::key_t                 ram_wdata;
	oaht_pkg::key_t                 ram_rdata;

	oaht_pkg::key_t                 q1;
	oaht_pkg::key_t                 rem1;
	logic [IW-1:0]                  r1_nx;
	oaht_pkg::key_t                 q2;
	oaht_pkg::key_t                 rem2;
	logic [HW-1:0]                  h2_nx;
	logic [P3W-1:0]                 p3;
	logic [HW-1:0]                  q3;
	logic [HW-1:0]                  rem3;
	logic [IW-1:0]                  h2n_nx;
	logic [IW:0]                    addr_sum;
	logic [IW-1:0]                  addr_nx;
	logic [IW:0]                    inc_sum;
	logic [IW-1:0]                  inc_nx;
	logic [IW:0]                    add_sum;
	logic [IW-1:0]                  add_nx;
	logic                           hit_empty;
	logic                           hit_match;
	logic [CW-1:0]                  count_inc;
	logic                           at_cap;
	logic [IW+oaht_pkg::SLOT_W-1:0]  slot_ext;
	logic [CW+oaht_pkg::COUNT_W-1:0] count_ext;
	logic                           out_load;

	// key slot storage
	oaht_ram #(
		.WIDTH(KW),
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	// finish the key residues and reduce the double-hash step mod TABLE_SIZE
	always_comb begin
		q1     = KW'(p1_q >> S1);
		rem1   = key_q - q1 * KEY_N;
		r1_nx  = rem1[IW-1:0];
		q2     = KW'(p2_q >> S2);
		rem2   = key_q - q2 * KEY_SP;
		h2_nx  = SP_H - rem2[HW-1:0];
		p3     = P3W'(h2_q) * P3W'(M3);
		q3     = HW'(p3 >> S3);
		rem3   = h2_q - q3 * STEP_N;
		h2n_nx = IW'(rem3);
	end

	// advance the probe address and its step terms, all mod TABLE_SIZE
	always_comb begin
		addr_sum = {1'b0, addr_q} + {1'b0, inc_q};
		addr_nx  = (addr_sum >= N_EXT) ? IW'(addr_sum - N_EXT) : addr_sum[IW-1:0];
		inc_sum  = {1'b0, inc_q} + {1'b0, add_q};
		inc_nx   = (inc_sum >= N_EXT) ? IW'(inc_sum - N_EXT) : inc_sum[IW-1:0];
		add_sum  = {1'b0, add_q} + (IW+1)'(2);
		add_nx   = (add_sum >= N_EXT) ? IW'(add_sum - N_EXT) : add_sum[IW-1:0];
		if (mode_q != oaht_pkg::MODE_QUAD) begin
			add_nx = add_q;
		end
	end

	// judge the slot read in the previous cycle
	always_comb begin
		hit_empty = (ram_rdata == '0);
		hit_match = !hit_empty && (op_q != oaht_pkg::OP_INSERT) && (ram_rdata == key_q);
		count_inc = count_q + CW'(1);
		at_cap    = (count_inc == CAP);
	end

	// RAM write: sweep, insert into empty slot, or zero a removed key
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = eval_idx_s1;
		ram_wdata = key_q;
		if (state_q == S_WIPE) begin
			ram_we    = 1'b1;
			ram_waddr = wipe_cnt_q;
			ram_wdata = '0;
		end else if (state_q == S_PROBE && eval_v_s1) begin
			if (hit_empty && op_q == oaht_pkg::OP_INSERT) begin
				ram_we = 1'b1;
			end else if (hit_match && op_q == oaht_pkg::OP_REMOVE) begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
		end
	end

	// hold the config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= oaht_pkg::MODE_LINEAR;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_WIPE;
			wipe_cnt_q <= '0;
			wipe_clr_q <= 1'b0;
			eval_v_s1  <= 1'b0;
			count_q    <= '0;
		end else begin
			case (state_q)
				S_WIPE: begin
					wipe_cnt_q <= wipe_cnt_q + IW'(1);
					if (wipe_cnt_q == LAST_IX) begin
						wipe_cnt_q <= '0;
						if (wipe_clr_q) begin
							res_status_q <= oaht_pkg::ST_CLEARED;
							res_slot_q   <= '0;
							res_count_q  <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q  <= req.opcode;
						key_q <= req.key;
						if (req.opcode == oaht_pkg::OP_CLEAR) begin
							wipe_clr_q <= 1'b1;
							state_q    <= S_WIPE;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					// reciprocal products for both residues
					p1_q    <= PW'(key_q) * PW'(M1);
					p2_q    <= PW'(key_q) * PW'(M2);
					state_q <= S_H2;
				end
				S_H2: begin
					r1_q    <= r1_nx;
					h2_q    <= h2_nx;
					state_q <= S_STEP;
				end
				S_STEP: begin
					addr_q    <= r1_q;
					count_q   <= '0;
					eval_v_s1 <= 1'b0;
					if (mode_q == oaht_pkg::MODE_QUAD) begin
						inc_q <= IW'(1);
						add_q <= IW'(3);
					end else if (mode_q == oaht_pkg::MODE_DOUBLE) begin
						inc_q <= h2n_nx;
						add_q <= h2n_nx;
					end else begin
						inc_q <= IW'(1);
						add_q <= '0;
					end
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					// read ahead along the sequence; drop the extra read on finish
					addr_q      <= addr_nx;
					inc_q       <= inc_nx;
					add_q       <= add_nx;
					eval_v_s1   <= 1'b1;
					eval_idx_s1 <= addr_q;
					if (eval_v_s1) begin
						if (hit_empty) begin
							res_count_q <= count_q;
							if (op_q == oaht_pkg::OP_INSERT) begin
								res_status_q <= oaht_pkg::ST_INSERTED;
								res_slot_q   <= eval_idx_s1;
							end else begin
								res_status_q <= oaht_pkg::ST_NOT_FOUND;
								res_slot_q   <= '0;
							end
							eval_v_s1 <= 1'b0;
							state_q   <= S_DONE;
						end else if (hit_match) begin
							res_count_q  <= count_inc;
							res_slot_q   <= eval_idx_s1;
							res_status_q <= (op_q == oaht_pkg::OP_REMOVE) ?
								oaht_pkg::ST_REMOVED : oaht_pkg::ST_FOUND;
							eval_v_s1    <= 1'b0;
							state_q      <= S_DONE;
						end else if (at_cap) begin
							res_count_q  <= count_inc;
							res_slot_q   <= '0;
							res_status_q <= (op_q == oaht_pkg::OP_INSERT) ?
								oaht_pkg::ST_FULL : oaht_pkg::ST_NOT_FOUND;
							eval_v_s1    <= 1'b0;
							state_q      <= S_DONE;
						end else begin
							count_q <= count_inc;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						wipe_clr_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// fit slot and count into the response fields
	always_comb begin
		slot_ext  = {{oaht_pkg::SLOT_W{1'b0}}, res_slot_q};
		count_ext = {{oaht_pkg::COUNT_W{1'b0}}, res_count_q};
		out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= 1'b1;
			out_status_q <= res_status_q;
			out_slot_q   <= slot_ext[oaht_pkg::SLOT_W-1:0];
			out_count_q  <= count_ext[oaht_pkg::COUNT_W-1:0];
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.slot        = out_slot_q;
	assign rsp.probe_count = out_count_q;

endmodule
`default_nettype wire
